// ----- sv/rcm_pkg.sv -----
// Shared types, constants and balance arithmetic for the random crossfade mixer.
package rcm_pkg;

    // Q1.14 unity and half, Q5.11 gate high threshold
    localparam logic [14:0]        ONE_Q14     = 15'd16384;
    localparam logic signed [15:0] HALF_Q14    = 16'sd8192;
    localparam logic signed [15:0] GATE_HIGH   = 16'sd2048;
    // ceil(2^23 / 10), exact floor(n / 10) for n below 2^22
    localparam logic [43:0]        RECIP_TENTH = 44'd838861;

    localparam int TDATA_IN_W  = 176;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 48;

    // Configuration register indexes
    localparam logic [1:0] CFG_KNOB_SPLIT = 2'd0;
    localparam logic [1:0] CFG_KNOB_INNER = 2'd1;
    localparam logic [1:0] CFG_KNOB_FINAL = 2'd2;

    // Gate source codes
    localparam logic [1:0] GATE_NONE = 2'd0;
    localparam logic [1:0] GATE_JACK = 2'd1;
    localparam logic [1:0] GATE_MAIN = 2'd2;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic signed [15:0] sample_ab;
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic [14:0]        split_l;
        logic [14:0]        split_r;
        logic [14:0]        lane_r0;
        logic [14:0]        lane_r1;
        logic [14:0]        final_r;
    } job_t;

    // knob + cv/5 in Q1.14, cv*8/5 rounded to nearest, clamped to +-1
    function automatic logic signed [15:0] balance_value(
        input logic signed [15:0] knob,
        input logic signed [15:0] cv
    );
        logic [15:0]        mag;
        logic [19:0]        num;
        logic [43:0]        prod;
        logic [15:0]        q;
        logic signed [17:0] sum;
        mag  = cv[15] ? 16'(-cv) : cv;
        num  = {mag, 4'b0000} + 20'd5;
        prod = 44'(num) * RECIP_TENTH;
        q    = prod[38:23];
        if (cv[15])
            sum = 18'(knob) - $signed({2'b00, q});
        else
            sum = 18'(knob) + $signed({2'b00, q});
        if (sum > 18'sd16384)
            sum = 18'sd16384;
        else if (sum < -18'sd16384)
            sum = -18'sd16384;
        return 16'(sum);
    endfunction

    // New right level of one balance unit
    function automatic logic [14:0] balance_unit(
        input logic [14:0]        held,
        input logic signed [15:0] bal,
        input logic               trig,
        input logic [15:0]        rnd
    );
        logic signed [17:0] t;
        logic [16:0]        lim;
        logic signed [15:0] lin;
        logic [14:0]        res;
        if (bal < 16'sd0)
            t = -18'(bal) - 18'sd8192;
        else
            t = 18'sd24576 - 18'(bal);
        lim = {t[14:0], 2'b00};
        lin = bal + HALF_Q14;
        if (bal > -HALF_Q14 && bal < HALF_Q14)
            res = lin[14:0];
        else if (trig)
            res = ({1'b0, rnd} > lim) ? 15'd0 : ONE_Q14;
        else
            res = held;
        return res;
    endfunction

    // Level doubled and clamped to unity
    function automatic logic [14:0] double_clamp(input logic [14:0] lvl);
        return (lvl >= 15'd8192) ? ONE_Q14 : {lvl[13:0], 1'b0};
    endfunction

endpackage

// ----- sv/random_crossfade_mixer_top.sv -----
// Top level of the random crossfade mixer: front end, item queue, back end.
//
// Input items arrive on s_tvalid/s_tready/s_tdata/s_tuser, one audio frame per
// item; results leave on m_tvalid/m_tready/m_tdata, one item per input item, in
// order. The three knobs are written through cfg_valid/cfg_index/cfg_data,
// always ready, and should be changed only while no item is in flight.
// The front end latches an item, forms the balance values, then computes the
// levels and trigger state and hands the item to a two-entry queue. The back end
// runs every product and mix on one shared multiply-accumulate and works on one
// item at a time; the front end can take a new item while the back end is still
// busy, as long as the queue has room.
// A stalled receiver holds the output register; the back end then waits, the
// queue fills and s_tready stays low until room frees up.
// Reset clears the queue and output valid, sets knob_mix_inner to 0.5 and the
// other knobs to 0, the trigger to high and all held levels to 0.
module random_crossfade_mixer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // sample_in_ab, sample_in_a, sample_in_b, cv_split, cv_mix_inner,
    // cv_mix_final, gate_voltage, rand_split, rand_lane0, rand_lane1, rand_final
    input  logic [rcm_pkg::TDATA_IN_W-1:0]    s_tdata,
    // gate_source
    input  logic [rcm_pkg::TUSER_IN_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_a, out_b, out_mix
    output logic [rcm_pkg::TDATA_OUT_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data
);

    logic          q_push, q_pop, q_full, q_empty;
    rcm_pkg::job_t q_in, q_head;

    assign cfg_ready = 1'b1;

    rcm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    rcm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    rcm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .job      (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- sv/rcm_front.sv -----
// Front end: accepts items, runs the Schmitt trigger and the four balance units.
module rcm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rcm_pkg::TDATA_IN_W-1:0]   s_tdata,
    input  logic [rcm_pkg::TUSER_IN_W-1:0]   s_tuser,
    input  logic                             cfg_valid,
    input  logic [1:0]                       cfg_index,
    input  logic [15:0]                      cfg_data,
    input  logic                             q_full,
    output logic                             q_push,
    output rcm_pkg::job_t                    q_data
);

    typedef enum logic [1:0] {F_IDLE, F_BAL, F_LVL} fstate_t;

    fstate_t            state_reg;
    logic signed [15:0] knob_split_reg, knob_inner_reg, knob_final_reg;
    logic signed [15:0] ab_reg, a_reg, b_reg, cvs_reg, cvi_reg, cvf_reg, gate_v_reg;
    logic [1:0]         gate_src_reg;
    logic [15:0]        rnd_split_reg, rnd_l0_reg, rnd_l1_reg, rnd_final_reg;
    logic signed [15:0] bal_split_reg, bal_inner_reg, bal_final_reg;
    logic               trig_high_reg;
    logic [14:0]        split_level_reg, final_level_reg;
    logic [14:0]        lane_level_reg [2];

    logic signed [15:0] gate;
    logic               trig_high_next, trig;
    logic [14:0]        r_split, l_split, split_r2, split_l2, r_l0, r_l1, r_fin;

    assign s_tready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_LVL) && !q_full;

    // gate selection and Schmitt trigger
    always_comb
    begin
        unique case (gate_src_reg)
            rcm_pkg::GATE_JACK: gate = gate_v_reg;
            rcm_pkg::GATE_MAIN: gate = ab_reg;
            default:            gate = 16'sd0;
        endcase
        trig_high_next = trig_high_reg;
        trig           = 1'b0;
        if (trig_high_reg)
        begin
            if (gate <= 16'sd0)
                trig_high_next = 1'b0;
        end
        else if (gate >= rcm_pkg::GATE_HIGH)
        begin
            trig_high_next = 1'b1;
            trig           = 1'b1;
        end
    end

    // balance units and stage 1 gain
    always_comb
    begin
        r_split  = rcm_pkg::balance_unit(split_level_reg, bal_split_reg, trig, rnd_split_reg);
        l_split  = rcm_pkg::ONE_Q14 - r_split;
        split_r2 = rcm_pkg::double_clamp(r_split);
        split_l2 = rcm_pkg::double_clamp(l_split);
        r_l0     = rcm_pkg::balance_unit(lane_level_reg[0], bal_inner_reg, trig, rnd_l0_reg);
        r_l1     = rcm_pkg::balance_unit(lane_level_reg[1], bal_inner_reg, trig, rnd_l1_reg);
        r_fin    = rcm_pkg::balance_unit(final_level_reg, bal_final_reg, trig, rnd_final_reg);

        q_data.sample_ab = ab_reg;
        q_data.sample_a  = a_reg;
        q_data.sample_b  = b_reg;
        q_data.split_l   = split_l2;
        q_data.split_r   = split_r2;
        q_data.lane_r0   = r_l0;
        q_data.lane_r1   = r_l1;
        q_data.final_r   = r_fin;
    end

    // sequencer, item latch, configuration and level state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= F_IDLE;
            knob_split_reg    <= 16'sd0;
            knob_inner_reg    <= 16'sd8192;
            knob_final_reg    <= 16'sd0;
            trig_high_reg     <= 1'b1;
            split_level_reg   <= 15'd0;
            lane_level_reg[0] <= 15'd0;
            lane_level_reg[1] <= 15'd0;
            final_level_reg   <= 15'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    rcm_pkg::CFG_KNOB_SPLIT: knob_split_reg <= cfg_data;
                    rcm_pkg::CFG_KNOB_INNER: knob_inner_reg <= cfg_data;
                    rcm_pkg::CFG_KNOB_FINAL: knob_final_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= F_BAL;
                end
                F_BAL:
                begin
                    state_reg <= F_LVL;
                end
                F_LVL:
                begin
                    if (!q_full)
                    begin
                        state_reg         <= F_IDLE;
                        trig_high_reg     <= trig_high_next;
                        split_level_reg   <= split_r2;
                        lane_level_reg[0] <= r_l0;
                        lane_level_reg[1] <= r_l1;
                        final_level_reg   <= r_fin;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

    // item fields and balance values
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            ab_reg        <= s_tdata[15:0];
            a_reg         <= s_tdata[31:16];
            b_reg         <= s_tdata[47:32];
            cvs_reg       <= s_tdata[63:48];
            cvi_reg       <= s_tdata[79:64];
            cvf_reg       <= s_tdata[95:80];
            gate_v_reg    <= s_tdata[111:96];
            rnd_split_reg <= s_tdata[127:112];
            rnd_l0_reg    <= s_tdata[143:128];
            rnd_l1_reg    <= s_tdata[159:144];
            rnd_final_reg <= s_tdata[175:160];
            gate_src_reg  <= s_tuser;
        end
        if (state_reg == F_BAL)
        begin
            bal_split_reg <= rcm_pkg::balance_value(knob_split_reg, cvs_reg);
            bal_inner_reg <= rcm_pkg::balance_value(knob_inner_reg, cvi_reg);
            bal_final_reg <= rcm_pkg::balance_value(knob_final_reg, cvf_reg);
        end
    end

endmodule

// ----- sv/rcm_queue.sv -----
// Two-entry queue of classified items between front and back.
module rcm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rcm_pkg::job_t push_data,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output rcm_pkg::job_t head
);

    rcm_pkg::job_t mem [2];
    logic          wr_ptr_reg, rd_ptr_reg;
    logic [1:0]    count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = mem[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ----- sv/rcm_back.sv -----
// Back end: products and mixes on one shared multiply-accumulate, output register.
module rcm_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_empty,
    input  rcm_pkg::job_t                    job,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rcm_pkg::TDATA_OUT_W-1:0]  m_tdata
);

    typedef enum logic [3:0] {
        B_IDLE, B_X0, B_X1, B_M0A, B_M0B, B_M1A, B_M1B, B_MIXA, B_MIXB, B_OUT
    } bstate_t;

    bstate_t            state_reg;
    logic signed [31:0] acc_reg;
    logic signed [15:0] x0_reg, x1_reg, m0_reg, m1_reg;
    logic signed [15:0] out_a_reg, out_b_reg, out_mix_reg;
    logic               m_tvalid_reg;

    logic signed [15:0] op_a;
    logic [14:0]        op_b;
    logic               op_add;
    logic signed [31:0] prod, acc_next;
    logic signed [15:0] acc_round;
    logic               out_load;

    // round Q?.25 back to Q5.11, ties up, then saturate
    function automatic logic signed [15:0] fin(input logic signed [31:0] v);
        logic signed [32:0] t;
        logic signed [18:0] s;
        t = 33'(v) + 33'sd8192;
        s = 19'(t >>> 14);
        if (s > 19'sd32767)
            return 16'sh7fff;
        else if (s < -19'sd32768)
            return 16'sh8000;
        else
            return 16'(s);
    endfunction

    // operand selection per step
    always_comb
    begin
        op_a   = 16'sd0;
        op_b   = 15'd0;
        op_add = 1'b0;
        unique case (state_reg)
            B_X0:   begin op_a = job.sample_ab; op_b = job.split_l; end
            B_X1:   begin op_a = job.sample_ab; op_b = job.split_r; end
            B_M0A:  begin op_a = x0_reg; op_b = rcm_pkg::ONE_Q14 - job.lane_r0; end
            B_M0B:  begin op_a = job.sample_a; op_b = job.lane_r0; op_add = 1'b1; end
            B_M1A:  begin op_a = x1_reg; op_b = rcm_pkg::ONE_Q14 - job.lane_r1; end
            B_M1B:  begin op_a = job.sample_b; op_b = job.lane_r1; op_add = 1'b1; end
            B_MIXA: begin op_a = m0_reg; op_b = rcm_pkg::ONE_Q14 - job.final_r; end
            B_MIXB: begin op_a = m1_reg; op_b = job.final_r; op_add = 1'b1; end
            default: ;
        endcase
        prod      = 32'(op_a) * 32'($signed({1'b0, op_b}));
        acc_next  = op_add ? acc_reg + prod : prod;
        acc_round = fin(acc_reg);
    end

    assign out_load = (state_reg == B_OUT) && (!m_tvalid_reg || m_tready);
    assign q_pop    = out_load;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_mix_reg, out_b_reg, out_a_reg};

    // step sequencer, accumulator and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
            acc_reg      <= 32'sd0;
            x0_reg       <= 16'sd0;
            x1_reg       <= 16'sd0;
            m0_reg       <= 16'sd0;
            m1_reg       <= 16'sd0;
            out_a_reg    <= 16'sd0;
            out_b_reg    <= 16'sd0;
            out_mix_reg  <= 16'sd0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready && !out_load)
                m_tvalid_reg <= 1'b0;
            if (state_reg != B_IDLE && state_reg != B_OUT)
                acc_reg <= acc_next;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                        state_reg <= B_X0;
                end
                B_X0:   state_reg <= B_X1;
                B_X1:   begin x0_reg <= acc_round; state_reg <= B_M0A; end
                B_M0A:  begin x1_reg <= acc_round; state_reg <= B_M0B; end
                B_M0B:  state_reg <= B_M1A;
                B_M1A:  begin m0_reg <= acc_round; state_reg <= B_M1B; end
                B_M1B:  state_reg <= B_MIXA;
                B_MIXA: begin m1_reg <= acc_round; state_reg <= B_MIXB; end
                B_MIXB: state_reg <= B_OUT;
                B_OUT:
                begin
                    if (out_load)
                    begin
                        out_a_reg    <= x0_reg;
                        out_b_reg    <= x1_reg;
                        out_mix_reg  <= acc_round;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule
